// ===== design/swmm_pkg.sv =====
`timescale 1ns / 1ps

package swmm_pkg;

    // Sample and result width, unsigned Q16.16.
    localparam int SAMPLE_W = 32;

    // Default number of samples held in the window.
    localparam int WINDOW_LENGTH_DEF = 60;

    // Value read for an empty slot, and the reset value of the minimum.
    localparam logic [SAMPLE_W-1:0] ALL_ONES = {SAMPLE_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // capture the input word and arm the scan
        logic rd_en;    // issue one ring read during the rescan
        logic commit;   // write the ring, update extremes, load the result
    } t_swmm_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic redo;     // the write slot holds the current max or min
    } t_swmm_status;

endpackage

// ===== design/swmm_datapath.sv =====
`timescale 1ns / 1ps

module swmm_datapath
    import swmm_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
    localparam int SLOT_W = $clog2(WINDOW_LENGTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_swmm_cmd           i_cmd,
    output t_swmm_status        o_status,
    input  logic [SAMPLE_W-1:0] i_loss_sample,
    output logic [SAMPLE_W-1:0] o_window_max,
    output logic [SAMPLE_W-1:0] o_window_min
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);

    // Ring storage and its per-slot valid marks.
    logic [SAMPLE_W-1:0]      r_ring [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] r_valid;

    logic [SLOT_W-1:0]   r_wslot;
    logic [SLOT_W-1:0]   r_rd_slot;
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_rd_vld;
    logic                r_cmp_en;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_redo_max;
    logic                r_redo_min;
    logic [SAMPLE_W-1:0] r_max_value;
    logic [SLOT_W-1:0]   r_max_slot;
    logic [SAMPLE_W-1:0] r_min_value;
    logic [SLOT_W-1:0]   r_min_slot;
    logic [SAMPLE_W-1:0] r_out_max;
    logic [SAMPLE_W-1:0] r_out_min;

    logic [SAMPLE_W-1:0] cand;
    logic                scan_max_hit;
    logic                scan_min_hit;
    logic                wr_max_hit;
    logic                wr_min_hit;
    logic [SAMPLE_W-1:0] n_max_value;
    logic [SAMPLE_W-1:0] n_min_value;
    logic [SLOT_W-1:0]   wslot_inc;
    logic [SLOT_W-1:0]   rd_slot_inc;

    // Slot pointers wrap from the last slot back to zero.
    assign wslot_inc   = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
    assign rd_slot_inc = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + 1'b1;

    // A rescan is needed when the slot about to be overwritten holds an extremum.
    assign o_status.redo = (r_wslot == r_max_slot) || (r_wslot == r_min_slot);

    // Compare terms for the scan stage and for the final write.
    always_comb begin
        cand         = r_rd_vld ? r_rd_data : ALL_ONES;
        scan_max_hit = r_cmp_en && r_redo_max && r_rd_vld && (cand > r_max_value);
        scan_min_hit = r_cmp_en && r_redo_min && (cand < r_min_value);
        wr_max_hit   = i_cmd.commit && (r_sample > r_max_value);
        wr_min_hit   = i_cmd.commit && (r_sample < r_min_value);
        n_max_value  = wr_max_hit ? r_sample : r_max_value;
        n_min_value  = wr_min_hit ? r_sample : r_min_value;
    end

    // Ring memory: one write port for the new word, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ring[r_wslot] <= r_sample;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_ring[r_rd_slot];
            r_rd_vld  <= r_valid[r_rd_slot];
        end
    end

    // Valid marks, write pointer and scan-stage enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_wslot  <= '0;
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_valid[r_wslot] <= 1'b1;
                r_wslot          <= wslot_inc;
            end
        end
    end

    // Captured word and the read pointer for the rescan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample  <= i_loss_sample;
            r_rd_slot <= wslot_inc;
        end else if (i_cmd.rd_en) begin
            r_rd_slot <= rd_slot_inc;
        end
    end

    // Running extremes: reset before a rescan, refined by each scan compare,
    // then merged with the new word at the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= '0;
            r_max_slot  <= '0;
            r_min_value <= ALL_ONES;
            r_min_slot  <= '0;
            r_redo_max  <= 1'b0;
            r_redo_min  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_redo_max <= (r_wslot == r_max_slot);
            r_redo_min <= (r_wslot == r_min_slot);
            if (r_wslot == r_max_slot) begin
                r_max_value <= '0;
            end
            if (r_wslot == r_min_slot) begin
                r_min_value <= ALL_ONES;
            end
        end else if (i_cmd.commit) begin
            r_max_value <= n_max_value;
            r_min_value <= n_min_value;
            if (wr_max_hit) begin
                r_max_slot <= r_wslot;
            end
            if (wr_min_hit) begin
                r_min_slot <= r_wslot;
            end
        end else begin
            if (scan_max_hit) begin
                r_max_value <= cand;
                r_max_slot  <= r_rd_slot - 1'b1 + ((r_rd_slot == '0) ? LAST_SLOT + 1'b1 : '0);
            end
            if (scan_min_hit) begin
                r_min_value <= cand;
                r_min_slot  <= r_rd_slot - 1'b1 + ((r_rd_slot == '0) ? LAST_SLOT + 1'b1 : '0);
            end
        end
    end

    // Output register for the result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_max <= n_max_value;
            r_out_min <= n_min_value;
        end
    end

    assign o_window_max = r_out_max;
    assign o_window_min = r_out_min;

    // The pointers always name a real slot.
    a_wslot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wslot <= LAST_SLOT)
        else $error("write slot out of range");

    a_max_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_slot <= LAST_SLOT && r_min_slot <= LAST_SLOT)
        else $error("extremum slot out of range");

    // The write marks the slot it fills as valid.
    a_wslot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_valid[$past(r_wslot)])
        else $error("written slot not marked valid");

endmodule

// ===== design/swmm_ctrl.sv =====
`timescale 1ns / 1ps

module swmm_ctrl
    import swmm_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
    localparam int SLOT_W = $clog2(WINDOW_LENGTH)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    input  t_swmm_status i_status,
    output t_swmm_cmd    o_cmd
);

    // Number of reads in a rescan is one less than the window.
    localparam logic [SLOT_W-1:0] LAST_CNT = SLOT_W'(WINDOW_LENGTH - 2);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_LAST  = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_scan_cnt;
    logic              r_out_valid;
    logic              out_free;
    t_swmm_cmd         cmd;

    // The result register can take a new word when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = i_status.redo ? ST_SCAN : ST_WRITE;
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (r_scan_cnt == LAST_CNT) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, scan counter and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.accept) begin
                r_scan_cnt <= '0;
            end else if (cmd.rd_en) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
            if (cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // An accepted word always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> r_state != ST_IDLE)
        else $error("accepted word did not start processing");

    // The final read of a rescan is followed by the compare-only cycle, then the write.
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN && r_scan_cnt == LAST_CNT |=> r_state == ST_LAST ##1
        r_state == ST_WRITE)
        else $error("rescan did not end on its last read");

    // A new result only appears from a write.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(cmd.commit))
        else $error("result valid without a write");

    // A write never overruns a result that is still held.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> r_state == ST_WRITE && (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule

// ===== design/sliding_window_min_max_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall  i_loss_sample[31:0]
// result    out        o_out_valid / i_out_stall o_window_max[31:0], o_window_min[31:0]
//
// A word that does not overwrite the slot holding the max or min goes from accept straight to the write.
// A word that does first passes through a rescan that reads the other WINDOW_LENGTH - 1
// ring slots through one memory read port, then a compare-only state, then the write.
// Reset is synchronous, active low; it clears the valid marks, pointers and extremes.
// The result sits in an output register, so a new word is taken while it waits;
// the write of the following result waits only while that register is still held.

module sliding_window_min_max_core
    import swmm_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [SAMPLE_W-1:0] i_loss_sample,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [SAMPLE_W-1:0] o_window_max,
    output logic [SAMPLE_W-1:0] o_window_min
);

    t_swmm_cmd    cmd;
    t_swmm_status status;

    // Sequencer for accept, rescan and write.
    swmm_ctrl #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Ring memory, extremes and result register.
    swmm_datapath #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_loss_sample (i_loss_sample),
        .o_window_max  (o_window_max),
        .o_window_min  (o_window_min)
    );

endmodule
